@@ rtl/ise_pkg.sv @@
// shared types, sizes and codes for the indexed stack engine
package ise_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);

	localparam int CMD_W  = 3;
	localparam int WORD_W = 32;
	localparam int POS_W  = 4;
	localparam int ST_W   = 2;
	localparam int LEN_W  = 5;

	// width wide enough to compare a position against the count
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH    = 3'd0,
		CMD_POP     = 3'd1,
		CMD_DISCARD = 3'd2,
		CMD_PEEK    = 3'd3,
		CMD_REVERSE = 3'd4,
		CMD_READ    = 3'd5,
		CMD_DELETE  = 3'd6,
		CMD_LENGTH  = 3'd7
	} cmd_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// one write and one read port request toward the entry store
	typedef struct packed {
		logic                  we;
		logic [ADDR_W-1:0]     waddr;
		logic [DATA_WIDTH-1:0] wdata;
		logic                  re;
		logic [ADDR_W-1:0]     raddr;
	} mem_req_t;

endpackage

@@ rtl/ise_store.sv @@
// entry store: one write port and one registered read port
module ise_store (
	input  logic                            clk,
	input  ise_pkg::mem_req_t               req,
	output logic [ise_pkg::DATA_WIDTH-1:0]  rdata
);
	import ise_pkg::*;

	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic [DATA_WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/indexed_stack_engine.sv @@
// indexed lifo stack engine: command sequencer, count and result register
// push, discard, length, reverse of one entry and any empty, range or full case
// register their result from the accepting cycle; pop, peek and read pass through
// S_RDOUT; delete at position p moves the p entries above it down, one entry moved
// per cycle through the store; reverse of n >= 2 entries runs S_REV_A, S_REV_B and S_REV_C per swap, then S_REV_FIN.
// busy is high while a command runs; the next word can start in the done cycle.
// arst_n clears the count, the sequencer and done; stored entries are not cleared.
module indexed_stack_engine (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [ise_pkg::CMD_W-1:0]    cmd,
	input  logic [ise_pkg::WORD_W-1:0]   push_word,
	input  logic [ise_pkg::POS_W-1:0]    position,
	output logic                         done,
	output logic [ise_pkg::WORD_W-1:0]   word_out,
	output logic [ise_pkg::ST_W-1:0]     status,
	output logic [ise_pkg::LEN_W-1:0]    length
);
	import ise_pkg::*;

	// sequencer states, one-hot
	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_RDOUT   = 7'b0000010,
		S_REV_A   = 7'b0000100,
		S_REV_B   = 7'b0001000,
		S_REV_C   = 7'b0010000,
		S_REV_FIN = 7'b0100000,
		S_DEL_MV  = 7'b1000000
	} state_t;

	state_t                state_q, state_d;
	logic [CNT_W-1:0]      count_q, count_d;
	logic [ADDR_W-1:0]     ptr_q, ptr_d;      // lower pointer / delete read pointer
	logic [ADDR_W-1:0]     jptr_q, jptr_d;    // upper pointer of reverse
	logic [ADDR_W-1:0]     jw_q, jw_d;        // upper slot awaiting its write
	logic [DATA_WIDTH-1:0] hold_q, hold_d;    // lower word of the swap in flight
	logic                  wpend_q, wpend_d;

	mem_req_t              mreq;
	logic [DATA_WIDTH-1:0] rdata;

	logic                  accept;
	cmd_t                  cmd_c;
	logic                  is_indexed;
	logic [CMP_W-1:0]      off_ext;
	logic [CMP_W-1:0]      cnt_ext;
	logic                  in_range;
	logic [ADDR_W-1:0]     slot;
	logic                  empty;
	logic                  full;

	logic                  emit;
	logic [DATA_WIDTH-1:0] emit_word;
	status_t               emit_status;

	logic                  done_q;
	logic [DATA_WIDTH-1:0] word_q;
	status_t               status_q;
	logic [CNT_W-1:0]      length_q;

	ise_store u_store (
		.clk   (clk),
		.req   (mreq),
		.rdata (rdata)
	);

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign cmd_c  = cmd_t'(cmd);

	// shared address unit: slot = count - 1 - offset, offset is zero for top-of-stack ops
	assign is_indexed = (cmd_c == CMD_READ) || (cmd_c == CMD_DELETE);
	assign off_ext    = is_indexed ? CMP_W'(position) : '0;
	assign cnt_ext    = CMP_W'(count_q);
	assign in_range   = off_ext < cnt_ext;
	assign slot       = ADDR_W'(cnt_ext - off_ext - CMP_W'(1));

	assign empty = (count_q == '0);
	assign full  = (count_q == CNT_W'(DEPTH));

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		ptr_d       = ptr_q;
		jptr_d      = jptr_q;
		jw_d        = jw_q;
		hold_d      = hold_q;
		wpend_d     = wpend_q;
		mreq        = '0;
		emit        = 1'b0;
		emit_word   = '0;
		emit_status = ST_OK;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (cmd_c)
						CMD_PUSH: begin
							emit = 1'b1;
							if (full) begin
								emit_status = ST_FULL;
							end else begin
								mreq.we    = 1'b1;
								mreq.waddr = ADDR_W'(count_q);
								mreq.wdata = DATA_WIDTH'(push_word);
								count_d    = count_q + CNT_W'(1);
							end
						end
						CMD_POP, CMD_PEEK, CMD_READ: begin
							if (!in_range) begin
								emit        = 1'b1;
								emit_status = ST_EMPTY;
							end else begin
								mreq.re    = 1'b1;
								mreq.raddr = slot;
								if (cmd_c == CMD_POP) begin
									count_d = count_q - CNT_W'(1);
								end
								state_d = S_RDOUT;
							end
						end
						CMD_DISCARD: begin
							emit = 1'b1;
							if (empty) begin
								emit_status = ST_EMPTY;
							end else begin
								count_d = count_q - CNT_W'(1);
							end
						end
						CMD_REVERSE: begin
							if (empty) begin
								emit        = 1'b1;
								emit_status = ST_EMPTY;
							end else if (count_q == CNT_W'(1)) begin
								emit = 1'b1;
							end else begin
								ptr_d   = '0;
								jptr_d  = slot;
								wpend_d = 1'b0;
								state_d = S_REV_A;
							end
						end
						CMD_DELETE: begin
							if (!in_range) begin
								emit        = 1'b1;
								emit_status = ST_EMPTY;
							end else if (off_ext == '0) begin
								// top entry: nothing to close up
								emit    = 1'b1;
								count_d = count_q - CNT_W'(1);
							end else begin
								mreq.re    = 1'b1;
								mreq.raddr = slot + ADDR_W'(1);
								ptr_d      = slot + ADDR_W'(1);
								state_d    = S_DEL_MV;
							end
						end
						CMD_LENGTH: begin
							emit = 1'b1;
						end
					endcase
				end
			end
			S_RDOUT: begin
				emit      = 1'b1;
				emit_word = rdata;
				state_d   = S_IDLE;
			end
			S_REV_A: begin
				// read lower slot, retire the previous upper write
				mreq.re    = 1'b1;
				mreq.raddr = ptr_q;
				if (wpend_q) begin
					mreq.we    = 1'b1;
					mreq.waddr = jw_q;
					mreq.wdata = hold_q;
				end
				state_d = S_REV_B;
			end
			S_REV_B: begin
				mreq.re    = 1'b1;
				mreq.raddr = jptr_q;
				hold_d     = rdata;
				state_d    = S_REV_C;
			end
			S_REV_C: begin
				mreq.we    = 1'b1;
				mreq.waddr = ptr_q;
				mreq.wdata = rdata;
				jw_d       = jptr_q;
				wpend_d    = 1'b1;
				ptr_d      = ptr_q + ADDR_W'(1);
				jptr_d     = jptr_q - ADDR_W'(1);
				if (({1'b0, ptr_q} + (ADDR_W+1)'(2)) < {1'b0, jptr_q}) begin
					state_d = S_REV_A;
				end else begin
					state_d = S_REV_FIN;
				end
			end
			S_REV_FIN: begin
				mreq.we    = 1'b1;
				mreq.waddr = jw_q;
				mreq.wdata = hold_q;
				emit       = 1'b1;
				state_d    = S_IDLE;
			end
			S_DEL_MV: begin
				// shift one entry down per cycle, reads stay ahead of writes
				mreq.we    = 1'b1;
				mreq.waddr = ptr_q - ADDR_W'(1);
				mreq.wdata = rdata;
				if ((CNT_W'(ptr_q) + CNT_W'(1)) < count_q) begin
					mreq.re    = 1'b1;
					mreq.raddr = ptr_q + ADDR_W'(1);
					ptr_d      = ptr_q + ADDR_W'(1);
				end else begin
					count_d = count_q - CNT_W'(1);
					emit    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			wpend_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			wpend_q <= wpend_d;
			done_q  <= emit;
		end
	end

	// datapath and result word
	always_ff @(posedge clk) begin
		ptr_q  <= ptr_d;
		jptr_q <= jptr_d;
		jw_q   <= jw_d;
		hold_q <= hold_d;
		if (emit) begin
			word_q   <= emit_word;
			status_q <= emit_status;
			length_q <= count_d;
		end
	end

	assign done     = done_q;
	assign word_out = WORD_W'(word_q);
	assign status   = status_q;
	assign length   = LEN_W'(length_q);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("stack count above depth");

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == S_IDLE))
		else $error("result shown while a command still runs");

	a_full_push: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (cmd_c == CMD_PUSH) && full) |=> (done_q && (status_q == ST_FULL)))
		else $error("push on full stack not flagged");

	a_del_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DEL_MV) |-> mreq.we)
		else $error("delete pass skipped a shift");

endmodule
